>>> hw/rtl/mma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared sizes, derived widths and the queue entry type for the
// multichannel moving average filter.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int WINDOW      = 128;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int CH_W     = 2;
  localparam int IN_W     = 12;
  localparam int FILT_W   = 16;
  localparam logic [FILT_W-1:0] FILT_MAX = 16'hFFFF;

  localparam int CHI_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW);
  localparam int RAM_DEPTH = CHANNELS * WINDOW;
  localparam int RA_W     = $clog2(RAM_DEPTH);

  // mean = floor(x / WINDOW), x = sum * 16, by reciprocal and one correction
  localparam int XW       = SUM_W + 4;
  localparam int RSH      = XW;
  localparam int RC_W     = RSH - $clog2(WINDOW) + 1;
  localparam longint unsigned RECIP_L = (64'd1 << RSH) / WINDOW;
  localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_L);
  localparam int PW       = XW + RC_W;

  localparam int QDEPTH   = 4;
  localparam int QP_W     = $clog2(QDEPTH);
  localparam int LVL_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             full;
    logic [SUM_W-1:0] data;
  } entry_t;

endpackage

>>> hw/rtl/mma_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_in_if
// Sample channel: channel tag and raw converter code with valid/ready.
// ----------------------------------------------------------------------------
interface mma_in_if;
  logic                      valid;
  logic                      ready;
  logic [mma_pkg::CH_W-1:0]  channel;
  logic [mma_pkg::IN_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

>>> hw/rtl/mma_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_out_if
// Result channel: channel, filtered value and window flag with valid/ready.
// ----------------------------------------------------------------------------
interface mma_out_if;
  logic                        valid;
  logic                        ready;
  logic [mma_pkg::CH_W-1:0]    out_channel;
  logic [mma_pkg::FILT_W-1:0]  filtered;
  logic                        window_full;

  modport source (output valid, output out_channel, output filtered,
                  output window_full, input ready);
  modport sink   (input valid, input out_channel, input filtered,
                  input window_full, output ready);
endinterface

>>> hw/rtl/mma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_front
// Accepts samples, drops out-of-range channels, keeps per-channel ring,
// write position, fill count and running sum, and pushes queue entries.
// ----------------------------------------------------------------------------
module mma_front (
  input  logic                       clk,
  input  logic                       rst_n,
  mma_in_if.sink                     in_ch,
  input  logic [mma_pkg::LVL_W-1:0]  q_level,
  output logic                       push,
  output mma_pkg::entry_t            push_entry
);

  logic [mma_pkg::POS_W-1:0] pos_r  [mma_pkg::CHANNELS];
  logic [mma_pkg::CNT_W-1:0] fill_r [mma_pkg::CHANNELS];
  logic [mma_pkg::SUM_W-1:0] sum_r  [mma_pkg::CHANNELS];
  logic [mma_pkg::SAMPLE_BITS-1:0] ring [mma_pkg::RAM_DEPTH];

  logic                            v1_r;
  logic [mma_pkg::CH_W-1:0]        ch1_r;
  logic [mma_pkg::CHI_W-1:0]       idx1_r;
  logic [mma_pkg::SAMPLE_BITS-1:0] s1_r;
  logic                            was1_r;
  logic                            now1_r;
  logic [mma_pkg::SAMPLE_BITS-1:0] old_r;

  logic                            acc;
  logic                            in_range;
  logic                            wr_en;
  logic [mma_pkg::CHI_W-1:0]       idx;
  logic [mma_pkg::POS_W-1:0]       pos;
  logic [mma_pkg::POS_W-1:0]       pos_nxt;
  logic [mma_pkg::CNT_W-1:0]       fill;
  logic                            was_full;
  logic                            now_full;
  logic [mma_pkg::RA_W-1:0]        addr;
  logic [mma_pkg::SAMPLE_BITS-1:0] s;
  logic [mma_pkg::SUM_W-1:0]       sum_sub;
  logic [mma_pkg::SUM_W-1:0]       sum_new;

  assign in_ch.ready = ({1'b0, q_level} + (mma_pkg::LVL_W + 1)'(v1_r))
                       < (mma_pkg::LVL_W + 1)'(mma_pkg::QDEPTH);
  assign acc      = in_ch.valid && in_ch.ready;
  assign in_range = int'(in_ch.channel) < mma_pkg::CHANNELS;
  assign wr_en    = acc && in_range;

  assign idx      = mma_pkg::CHI_W'(in_ch.channel);
  assign pos      = pos_r[idx];
  assign fill     = fill_r[idx];
  assign s        = mma_pkg::SAMPLE_BITS'(in_ch.sample);
  assign was_full = fill == mma_pkg::CNT_W'(mma_pkg::WINDOW);
  assign now_full = was_full || (fill == mma_pkg::CNT_W'(mma_pkg::WINDOW - 1));
  assign pos_nxt  = (pos == mma_pkg::POS_W'(mma_pkg::WINDOW - 1)) ?
                    '0 : pos + mma_pkg::POS_W'(1);
  assign addr     = mma_pkg::RA_W'(int'(idx) * mma_pkg::WINDOW + int'(pos));

  // read-first ring port: old entry comes back in the next cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      old_r      <= ring[addr];
      ring[addr] <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      v1_r <= wr_en;
      if (wr_en) begin
        pos_r[idx] <= pos_nxt;
        if (!was_full) begin
          fill_r[idx] <= fill + mma_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ch1_r  <= in_ch.channel;
      idx1_r <= idx;
      s1_r   <= s;
      was1_r <= was_full;
      now1_r <= now_full;
    end
  end

  assign sum_sub = was1_r ? mma_pkg::SUM_W'(old_r) : '0;
  assign sum_new = sum_r[idx1_r] - sum_sub + mma_pkg::SUM_W'(s1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        sum_r[i] <= '0;
      end
    end else if (v1_r) begin
      sum_r[idx1_r] <= sum_new;
    end
  end

  assign push            = v1_r;
  assign push_entry.ch   = ch1_r;
  assign push_entry.full = now1_r;
  assign push_entry.data = now1_r ? sum_new : mma_pkg::SUM_W'(s1_r);

endmodule

>>> hw/rtl/mma_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_queue
// Short register FIFO between the front and the averaging back end.
// ----------------------------------------------------------------------------
module mma_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  mma_pkg::entry_t            push_entry,
  input  logic                       pop,
  output logic                       head_valid,
  output mma_pkg::entry_t            head,
  output logic [mma_pkg::LVL_W-1:0]  level
);

  mma_pkg::entry_t              mem_r [mma_pkg::QDEPTH];
  logic [mma_pkg::QP_W-1:0]     wp_r;
  logic [mma_pkg::QP_W-1:0]     rp_r;
  logic [mma_pkg::LVL_W-1:0]    cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rp_r];
  assign level      = cnt_r;
  assign do_push    = push && (cnt_r != mma_pkg::LVL_W'(mma_pkg::QDEPTH));
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == mma_pkg::QP_W'(mma_pkg::QDEPTH - 1)) ?
                '0 : wp_r + mma_pkg::QP_W'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == mma_pkg::QP_W'(mma_pkg::QDEPTH - 1)) ?
                '0 : rp_r + mma_pkg::QP_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + mma_pkg::LVL_W'(1);
        2'b01:   cnt_r <= cnt_r - mma_pkg::LVL_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/mma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_back
// Turns queue entries into results: mean by reciprocal multiply with one
// correction step, fill-phase pass-through, saturation, output register.
// ----------------------------------------------------------------------------
module mma_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  mma_pkg::entry_t  head,
  output logic             pop,
  mma_out_if.source        out_ch
);

  logic                        v1_r;
  logic [mma_pkg::CH_W-1:0]    ch1_r;
  logic                        full1_r;
  logic [mma_pkg::XW-1:0]      x1_r;
  logic [mma_pkg::PW-1:0]      prod1_r;

  logic                        v2_r;
  logic [mma_pkg::CH_W-1:0]    ch2_r;
  logic                        full2_r;
  logic [mma_pkg::XW-1:0]      x2_r;
  logic [mma_pkg::XW-1:0]      q0_2_r;
  logic [mma_pkg::XW-1:0]      qw2_r;

  logic                        ov_r;
  logic [mma_pkg::CH_W-1:0]    och_r;
  logic [mma_pkg::FILT_W-1:0]  ofilt_r;
  logic                        ofull_r;

  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy_o;
  logic [mma_pkg::XW-1:0]      x_in;
  logic [mma_pkg::XW-1:0]      q0;
  logic [mma_pkg::XW-1:0]      rem;
  logic [mma_pkg::XW-1:0]      quot;
  logic [mma_pkg::XW-1:0]      val;

  assign rdy_o = !ov_r || out_ch.ready;
  assign rdy2  = !v2_r || rdy_o;
  assign rdy1  = !v1_r || rdy2;
  assign pop   = head_valid && rdy1;

  assign x_in  = {head.data, 4'b0000};
  assign q0    = mma_pkg::XW'(prod1_r >> mma_pkg::RSH);
  assign rem   = x2_r - qw2_r;
  assign quot  = (rem >= mma_pkg::XW'(mma_pkg::WINDOW)) ?
                 q0_2_r + mma_pkg::XW'(1) : q0_2_r;
  assign val   = full2_r ? quot : x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= head_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy_o) begin
        ov_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch1_r   <= head.ch;
      full1_r <= head.full;
      x1_r    <= x_in;
      prod1_r <= mma_pkg::PW'(x_in) * mma_pkg::PW'(mma_pkg::RECIP);
    end
    if (rdy2 && v1_r) begin
      ch2_r   <= ch1_r;
      full2_r <= full1_r;
      x2_r    <= x1_r;
      q0_2_r  <= q0;
      qw2_r   <= mma_pkg::XW'(q0 * mma_pkg::XW'(mma_pkg::WINDOW));
    end
    if (rdy_o && v2_r) begin
      och_r   <= ch2_r;
      ofull_r <= full2_r;
      ofilt_r <= (32'(val) > 32'(mma_pkg::FILT_MAX)) ?
                 mma_pkg::FILT_MAX : mma_pkg::FILT_W'(val);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_channel = och_r;
  assign out_ch.filtered    = ofilt_r;
  assign out_ch.window_full = ofull_r;

endmodule

>>> hw/rtl/multichannel_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel moving average of tagged converter samples, unsigned 12.4.
//
// One sample is taken every cycle when the queue has room, any channel
// order. The ring memory is a single read-first port, so each sample reads
// the entry it overwrites in the same cycle and the running sum is updated
// in the next cycle; this sets the rate at one sample per cycle. Samples
// with a channel number at or above the channel count are dropped with no
// result. The ring needs no clearing after reset: an entry is only
// subtracted once the window is full.
// ----------------------------------------------------------------------------
module multichannel_moving_average (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_ch,
  mma_out_if.source  out_ch
);

  logic                       push;
  mma_pkg::entry_t            push_entry;
  logic                       pop;
  logic                       head_valid;
  mma_pkg::entry_t            head;
  logic [mma_pkg::LVL_W-1:0]  q_level;

  mma_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_level    (q_level),
    .push       (push),
    .push_entry (push_entry)
  );

  mma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  mma_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> tb/mma_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_average_checker
// Watches the sample and result channels of the moving average filter. Every
// accepted sample updates a per-channel window model. That model predicts
// the filtered result, which is queued. Each result transfer is compared
// field by field with the oldest queued prediction. Mismatches are counted
// and handed to the top.
// ----------------------------------------------------------------------------
module mma_average_checker
  import mma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mma_in_if           in_mon,
  mma_out_if          out_mon,
  output int unsigned errors,
  output int unsigned pending
);

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [FILT_W-1:0] value;
    logic              full;
  } avg_t;

  logic [SAMPLE_BITS-1:0] ring [CHANNELS][WINDOW];
  int unsigned            wr_pos [CHANNELS];
  int unsigned            held [CHANNELS];
  longint unsigned        acc [CHANNELS];
  avg_t                   avg_due [$];

  function automatic void track_sample(input logic [CH_W-1:0] ch,
                                       input logic [IN_W-1:0] code);
    int unsigned            c;
    logic [SAMPLE_BITS-1:0] s;
    bit                     was_full;
    longint unsigned        mean;
    avg_t                   r;
    c = ch;
    if (c >= CHANNELS) return;
    s = SAMPLE_BITS'(code);
    was_full = held[c] >= WINDOW;
    // oldest sample leaves the window only once it is full
    if (was_full) acc[c] -= longint'(ring[c][wr_pos[c]]);
    acc[c] += longint'(s);
    ring[c][wr_pos[c]] = s;
    wr_pos[c] = (wr_pos[c] + 1) % WINDOW;
    if (!was_full) held[c]++;
    r.ch = ch;
    r.full = held[c] >= WINDOW;
    if (r.full) mean = (acc[c] << 4) / WINDOW;
    else mean = longint'(s) << 4;
    if (mean > longint'(FILT_MAX)) mean = longint'(FILT_MAX);
    r.value = FILT_W'(mean);
    avg_due.push_back(r);
  endfunction

  always @(posedge clk) begin : watch
    avg_t got;
    avg_t want;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_pos[i] = 0;
        held[i] = 0;
        acc[i] = 0;
      end
      avg_due.delete();
      errors = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) track_sample(in_mon.channel, in_mon.sample);
      if (out_mon.valid && out_mon.ready) begin
        got.ch = out_mon.out_channel;
        got.value = out_mon.filtered;
        got.full = out_mon.window_full;
        if (avg_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ch=%0d filtered=%0d full=%0b",
                   $time, got.ch, got.value, got.full);
        end else begin
          want = avg_due.pop_front();
          if (got.ch !== want.ch || got.value !== want.value || got.full !== want.full) begin
            errors++;
            $display("%0t: result mismatch exp ch=%0d filtered=%0d full=%0b, got ch=%0d filtered=%0d full=%0b",
                     $time, want.ch, want.value, want.full, got.ch, got.value, got.full);
          end
        end
      end
    end
    pending = avg_due.size();
  end

endmodule

>>> tb/tb_multichannel_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_moving_average
// Regression for the multichannel moving average filter. Corner codes go to
// every channel first. Random traffic follows, with runs on one channel and
// windows pinned at full scale and at zero. Sender gaps and receiver stalls
// come in bursts, and the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_multichannel_moving_average;
  import mma_pkg::*;

  typedef enum int {MIX_UNIFORM, MIX_PINNED, MIX_EDGES} mix_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches;
  int unsigned avg_pending;

  mma_in_if  in_bus ();
  mma_out_if out_bus ();

  multichannel_moving_average u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  mma_average_checker u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_bus),
    .out_mon (out_bus),
    .errors  (mismatches),
    .pending (avg_pending)
  );

  always #1 clk = ~clk;

  initial begin : watchdog
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sink_ready
    int n;
    out_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 4);
        out_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  // called and returns at a falling edge
  task automatic push_sample(input logic [CH_W-1:0] ch, input logic [IN_W-1:0] s);
    int gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= s;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n, input mix_e mix);
    logic [CH_W-1:0] ch;
    logic [IN_W-1:0] s;
    ch = '0;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) ch = CH_W'($urandom_range(0, CHANNELS - 1));
      s = IN_W'($urandom);
      case (mix)
        MIX_PINNED: begin
          if (ch == 0 && $urandom_range(0, 15) != 0) s = {IN_W{1'b1}};
          else if (ch == 1 && $urandom_range(0, 15) != 0) s = {IN_W{1'b0}};
        end
        MIX_EDGES: begin
          if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 1) ? {IN_W{1'b1}} : {IN_W{1'b0}};
        end
        default: ;
      endcase
      push_sample(ch, s);
    end
  endtask

  initial begin : stimulus
    logic [IN_W-1:0] corner [4];
    corner = '{12'h000, 12'hFFF, 12'hAAA, 12'h555};
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.sample = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_pct = 20;
    stall_pct = 20;
    foreach (corner[i]) begin
      for (int c = 0; c < CHANNELS; c++) push_sample(CH_W'(c), corner[i]);
    end
    gap_pct = 25;
    stall_pct = 25;
    run_phase(600, MIX_PINNED);
    gap_pct = 50;
    stall_pct = 10;
    run_phase(350, MIX_UNIFORM);
    gap_pct = 0;
    stall_pct = 0;
    run_phase(200, MIX_EDGES);
    in_bus.valid <= 1'b0;
    while (avg_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && avg_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
